FILE: hdl/mcfg_pkg.sv
// ----------------------------------------------------------------------------
// mcfg_pkg
// Shared types for the multi-camera frame grouper: transaction payloads,
// result kinds and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package mcfg_pkg;

  localparam int CAM_FIELD_W    = 3;
  localparam int HANDLE_FIELD_W = 16;
  localparam int HELD_FIELD_W   = 4;

  typedef enum logic {
    FUNC_ADD   = 1'b0,
    FUNC_FETCH = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    KIND_DELIVERED = 2'd0,
    KIND_FREED     = 2'd1,
    KIND_ADD_DONE  = 2'd2,
    KIND_NOT_READY = 2'd3
  } kind_t;

  typedef struct packed {
    func_t                     func;
    logic [CAM_FIELD_W-1:0]    camera_index;
    logic [HANDLE_FIELD_W-1:0] frame_handle;
  } in_item_t;

  typedef struct packed {
    kind_t                     kind;
    logic [CAM_FIELD_W-1:0]    camera_index_res;
    logic [HANDLE_FIELD_W-1:0] frame_handle_res;
    logic                      last;
    logic [HELD_FIELD_W-1:0]   groups_held;
  } out_item_t;

  // group count reported with a result, relative to the current count
  typedef enum logic [1:0] {
    HELD_CUR,
    HELD_INC,
    HELD_DEC
  } held_t;

  // camera field source of a result
  typedef enum logic [1:0] {
    CAM_NONE,
    CAM_INPUT,
    CAM_CNT
  } cam_sel_t;

  typedef struct packed {
    logic     capture;    // latch the input transaction, clear camera counter
    logic     rd_en;      // read fill mask and handle RAMs
    logic     rd_head;    // 1: oldest group at counter camera, 0: newest at input camera
    logic     cnt_inc;
    logic     wr_en;      // write handle and fill mask
    logic     wr_open;    // 1: open a new group at the tail, 0: update the newest
    logic     pop;        // retire the oldest group
    logic     emit_en;
    kind_t    emit_kind;
    logic     emit_last;
    held_t    held_sel;
    cam_sel_t cam_sel;
  } cmd_t;

  typedef struct packed {
    logic is_fetch;
    logic cam_ok;
    logic waiting;
    logic count_zero;
    logic full;
    logic has_cam;     // fill mask holds the input camera
    logic complete;    // fill mask has every camera
    logic fill_any;
    logic cnt_filled;  // fill mask holds the counter camera
    logic cnt_last;    // counter at the last camera
    logic cnt_is_top;  // counter at the highest filled camera
  } sts_t;

endpackage

FILE: hdl/mcfg_ram.sv
// ----------------------------------------------------------------------------
// mcfg_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mcfg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                        wr_data,
  input  logic                                    rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hdl/mcfg_dp.sv
// ----------------------------------------------------------------------------
// mcfg_dp
// Datapath: handle and fill-mask RAMs, ring pointers, group count, camera
// counter and the result register.
// ----------------------------------------------------------------------------
module mcfg_dp import mcfg_pkg::*; #(
  parameter int GROUP_DEPTH  = 8,
  parameter int NUM_CAMERAS  = 2,
  parameter int HANDLE_WIDTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_item,
  input  cmd_t      cmd,
  output sts_t      sts,
  output logic      out_valid,
  output out_item_t out_item
);

  localparam int GW        = (GROUP_DEPTH > 1) ? $clog2(GROUP_DEPTH) : 1;
  localparam int CAM_W     = (NUM_CAMERAS > 1) ? $clog2(NUM_CAMERAS) : 1;
  localparam int CNT_W     = $clog2(GROUP_DEPTH + 1);
  localparam int SW        = (HANDLE_WIDTH < HANDLE_FIELD_W) ? HANDLE_WIDTH : HANDLE_FIELD_W;
  localparam int HDL_DEPTH = ((GROUP_DEPTH > 1) ? GROUP_DEPTH : 2) << CAM_W;
  localparam logic [NUM_CAMERAS-1:0] FULL_MASK = '1;

  func_t                  func_r;
  logic [CAM_FIELD_W-1:0] cam_r;
  logic [SW-1:0]          hdl_r;
  logic [CAM_W-1:0]       cnt_r, cnt_nxt;
  logic [GW-1:0]          head_r, head_nxt;
  logic [GW-1:0]          tail_r, tail_nxt;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic                   waiting_r, waiting_nxt;
  logic                   out_valid_r;
  out_item_t              out_item_r, out_item_nxt;

  logic [CAM_W-1:0]       cam_idx;
  logic [NUM_CAMERAS-1:0] cam_onehot;
  logic [NUM_CAMERAS-1:0] cnt_onehot;
  logic [GW-1:0]          newest;
  logic [GW-1:0]          rd_grp, wr_grp;
  logic [CAM_W-1:0]       rd_cam;
  logic [NUM_CAMERAS-1:0] fill_q, fill_wdata;
  logic [SW-1:0]          hdl_q;
  logic [CAM_W-1:0]       top_cam;
  logic [CNT_W-1:0]       held_val;
  logic                   push;
  logic                   full;

  assign cam_idx    = cam_r[CAM_W-1:0];
  assign cam_onehot = NUM_CAMERAS'(1) << cam_idx;
  assign cnt_onehot = NUM_CAMERAS'(1) << cnt_r;
  assign newest     = (tail_r == '0) ? GW'(GROUP_DEPTH - 1) : tail_r - 1'b1;
  assign rd_grp     = cmd.rd_head ? head_r : newest;
  assign rd_cam     = cmd.rd_head ? cnt_r : cam_idx;
  assign wr_grp     = cmd.wr_open ? tail_r : newest;
  assign fill_wdata = cmd.wr_open ? cam_onehot : (fill_q | cam_onehot);
  assign push       = cmd.wr_en & cmd.wr_open;
  assign full       = (count_r == CNT_W'(GROUP_DEPTH));

  mcfg_ram #(
    .WIDTH (NUM_CAMERAS),
    .DEPTH (GROUP_DEPTH)
  ) u_fill_ram (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr (wr_grp),
    .wr_data (fill_wdata),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_grp),
    .rd_data (fill_q)
  );

  mcfg_ram #(
    .WIDTH (SW),
    .DEPTH (HDL_DEPTH)
  ) u_hdl_ram (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr ({wr_grp, cam_idx}),
    .wr_data (hdl_r),
    .rd_en   (cmd.rd_en),
    .rd_addr ({rd_grp, rd_cam}),
    .rd_data (hdl_q)
  );

  // highest filled camera, marks the final freed handle of a dropped group
  always_comb begin
    top_cam = '0;
    for (int i = 0; i < NUM_CAMERAS; i++) begin
      if (fill_q[i]) top_cam = CAM_W'(i);
    end
  end

  always_comb begin
    sts.is_fetch   = (func_r == FUNC_FETCH);
    sts.cam_ok     = ({1'b0, cam_r} < (CAM_FIELD_W + 1)'(NUM_CAMERAS));
    sts.waiting    = waiting_r;
    sts.count_zero = (count_r == '0);
    sts.full       = full;
    sts.has_cam    = |(fill_q & cam_onehot);
    sts.complete   = (fill_q == FULL_MASK);
    sts.fill_any   = |fill_q;
    sts.cnt_filled = |(fill_q & cnt_onehot);
    sts.cnt_last   = (cnt_r == CAM_W'(NUM_CAMERAS - 1));
    sts.cnt_is_top = (cnt_r == top_cam);
  end

  always_comb begin
    cnt_nxt     = cnt_r;
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    count_nxt   = count_r;
    waiting_nxt = waiting_r;
    if (cmd.capture) begin
      cnt_nxt = '0;
    end else if (cmd.cnt_inc) begin
      cnt_nxt = cnt_r + 1'b1;
    end
    if (cmd.pop) begin
      head_nxt  = (head_r == GW'(GROUP_DEPTH - 1)) ? '0 : head_r + 1'b1;
      count_nxt = count_r - 1'b1;
    end
    if (push) begin
      tail_nxt  = (tail_r == GW'(GROUP_DEPTH - 1)) ? '0 : tail_r + 1'b1;
      count_nxt = count_r + 1'b1;
    end
    if (cmd.wr_en) begin
      waiting_nxt = (fill_wdata != FULL_MASK);
    end
  end

  always_comb begin
    case (cmd.held_sel)
      HELD_INC: held_val = count_r + 1'b1;
      HELD_DEC: held_val = count_r - 1'b1;
      default:  held_val = count_r;
    endcase
    out_item_nxt = out_item_r;
    if (cmd.emit_en) begin
      out_item_nxt.kind = cmd.emit_kind;
      case (cmd.cam_sel)
        CAM_INPUT: out_item_nxt.camera_index_res = cam_r;
        CAM_CNT:   out_item_nxt.camera_index_res = CAM_FIELD_W'(cnt_r);
        default:   out_item_nxt.camera_index_res = '0;
      endcase
      if (cmd.emit_kind == KIND_DELIVERED || cmd.emit_kind == KIND_FREED) begin
        out_item_nxt.frame_handle_res = HANDLE_FIELD_W'(hdl_q);
      end else begin
        out_item_nxt.frame_handle_res = '0;
      end
      out_item_nxt.last        = cmd.emit_last;
      out_item_nxt.groups_held = HELD_FIELD_W'(held_val);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      waiting_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      waiting_r   <= waiting_nxt;
      out_valid_r <= cmd.emit_en;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r <= in_item.func;
      cam_r  <= in_item.camera_index;
      hdl_r  <= in_item.frame_handle[SW-1:0];
    end
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(GROUP_DEPTH))
    else $error("group count above depth");

  a_waiting_has_group: assert property (@(posedge clk) disable iff (!rst_n)
    waiting_r |-> count_r != '0)
    else $error("incomplete newest group with an empty FIFO");

  a_open_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("group opened while FIFO full");

endmodule

FILE: hdl/mcfg_ctrl.sv
// ----------------------------------------------------------------------------
// mcfg_ctrl
// Controller: sequences add, replace, drop and fetch over the datapath,
// one transaction at a time.
// ----------------------------------------------------------------------------
module mcfg_ctrl import mcfg_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_REPLACE,
    S_DROP_EM,
    S_DROP_RD,
    S_OPEN,
    S_FETCH_EM,
    S_FETCH_RD
  } state_t;

  state_t state_r, state_nxt;
  logic   dropped_r, dropped_nxt;

  always_comb begin
    cmd         = '0;
    state_nxt   = state_r;
    dropped_nxt = dropped_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts.is_fetch) begin
          if (sts.count_zero) begin
            cmd.emit_en   = 1'b1;
            cmd.emit_kind = KIND_NOT_READY;
            cmd.emit_last = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            cmd.rd_en   = 1'b1;
            cmd.rd_head = 1'b1;
            state_nxt   = S_FETCH_EM;
          end
        end else if (!sts.cam_ok) begin
          cmd.emit_en   = 1'b1;
          cmd.emit_kind = KIND_ADD_DONE;
          cmd.emit_last = 1'b1;
          state_nxt     = S_IDLE;
        end else if (sts.waiting && !sts.count_zero) begin
          cmd.rd_en = 1'b1;
          state_nxt = S_REPLACE;
        end else if (sts.full) begin
          cmd.rd_en   = 1'b1;
          cmd.rd_head = 1'b1;
          dropped_nxt = 1'b1;
          state_nxt   = S_DROP_EM;
        end else begin
          dropped_nxt = 1'b0;
          state_nxt   = S_OPEN;
        end
      end
      S_REPLACE: begin
        cmd.wr_en     = 1'b1;
        cmd.emit_en   = 1'b1;
        cmd.emit_last = 1'b1;
        if (sts.has_cam) begin
          cmd.emit_kind = KIND_FREED;
          cmd.cam_sel   = CAM_INPUT;
        end else begin
          cmd.emit_kind = KIND_ADD_DONE;
        end
        state_nxt = S_IDLE;
      end
      S_DROP_EM: begin
        if (sts.cnt_filled) begin
          cmd.emit_en   = 1'b1;
          cmd.emit_kind = KIND_FREED;
          cmd.cam_sel   = CAM_CNT;
          cmd.emit_last = sts.cnt_is_top;
        end
        if (sts.cnt_last) begin
          cmd.pop   = 1'b1;
          state_nxt = S_OPEN;
        end else begin
          cmd.cnt_inc = 1'b1;
          state_nxt   = S_DROP_RD;
        end
      end
      S_DROP_RD: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_head = 1'b1;
        state_nxt   = S_DROP_EM;
      end
      S_OPEN: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_open = 1'b1;
        // fill mask still holds the dropped group here
        if (!(dropped_r && sts.fill_any)) begin
          cmd.emit_en   = 1'b1;
          cmd.emit_kind = KIND_ADD_DONE;
          cmd.emit_last = 1'b1;
          cmd.held_sel  = HELD_INC;
        end
        state_nxt = S_IDLE;
      end
      S_FETCH_EM: begin
        cmd.emit_en = 1'b1;
        if (!sts.complete) begin
          cmd.emit_kind = KIND_NOT_READY;
          cmd.emit_last = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          cmd.emit_kind = KIND_DELIVERED;
          cmd.cam_sel   = CAM_CNT;
          cmd.emit_last = sts.cnt_last;
          cmd.held_sel  = HELD_DEC;
          if (sts.cnt_last) begin
            cmd.pop   = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            cmd.cnt_inc = 1'b1;
            state_nxt   = S_FETCH_RD;
          end
        end
      end
      S_FETCH_RD: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_head = 1'b1;
        state_nxt   = S_FETCH_EM;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      dropped_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      dropped_r <= dropped_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("no work started after an accepted transaction");

  a_fetch_pop_last: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop && state_r == S_FETCH_EM |-> cmd.emit_en && cmd.emit_last)
    else $error("fetch pop without final delivered handle");

  a_pop_states: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> state_r == S_DROP_EM || state_r == S_FETCH_EM)
    else $error("group retired outside drop or fetch");

endmodule

FILE: hdl/multi_camera_frame_grouper.sv
// ----------------------------------------------------------------------------
// multi_camera_frame_grouper
// FIFO of frame groups, one handle slot per camera. Adds fill the newest
// incomplete group (replacing and freeing an old handle) or open a new one,
// dropping the oldest group when full; fetches pop a complete oldest group.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                  payload
//  input     in         start / busy               in_item  (in_item_t)
//  result    out        out_valid strobe, 1 cycle  out_item (out_item_t)
//
//  An add that drops the oldest group and a fetch that delivers both walk
//  the N = NUM_CAMERAS handle slots of the oldest group in turn. The handle
//  RAM has a single registered read port, so each handle is read into its
//  read register before the result that carries it is emitted.
//  Reset is synchronous, active low; the RAMs are not cleared and need no
//  clearing pass. Each result shows for one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
module multi_camera_frame_grouper import mcfg_pkg::*; #(
  parameter int GROUP_DEPTH  = 8,
  parameter int NUM_CAMERAS  = 2,
  parameter int HANDLE_WIDTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  cmd_t cmd;
  sts_t sts;

  mcfg_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  mcfg_dp #(
    .GROUP_DEPTH  (GROUP_DEPTH),
    .NUM_CAMERAS  (NUM_CAMERAS),
    .HANDLE_WIDTH (HANDLE_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

FILE: tb/sv/multi_camera_frame_grouper_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_camera_frame_grouper_test
// Self-checking bench for the frame grouper. Directed adds and fetches cover
// replacement, group completion, full-FIFO drops and not-ready fetches. Random
// phases then alternate between fill-heavy and drain-heavy traffic with random
// sender gaps. A scoreboard predicts every result and checks it field by field.
// ----------------------------------------------------------------------------
module multi_camera_frame_grouper_test;
  import mcfg_pkg::*;

  localparam int GROUP_DEPTH  = 8;
  localparam int NUM_CAMERAS  = 2;
  localparam int HANDLE_WIDTH = 16;
  localparam int CYCLE_LIMIT  = 200000;

  class frame_group_scoreboard;
    logic [HANDLE_FIELD_W-1:0] handle_store [GROUP_DEPTH][NUM_CAMERAS];
    bit [NUM_CAMERAS-1:0]      slot_filled [GROUP_DEPTH];
    int unsigned               oldest;
    int unsigned               held;
    bit                        waiting;
    out_item_t                 pending_results [$];
    int                        error_count;

    function new();
      foreach (slot_filled[g]) slot_filled[g] = '0;
      oldest = 0;
      held = 0;
      waiting = 1'b0;
      error_count = 0;
    endfunction

    function out_item_t make_result(kind_t k, int cam, logic [HANDLE_FIELD_W-1:0] h);
      out_item_t r;
      r = '0;
      r.kind = k;
      r.camera_index_res = cam[CAM_FIELD_W-1:0];
      r.frame_handle_res = h;
      return r;
    endfunction

    // work out the results of one accepted transaction and update the grouping
    function void note_input(in_item_t it);
      out_item_t step [$];
      out_item_t r;
      int unsigned g;
      int cam;
      cam = it.camera_index;
      if (it.func == FUNC_ADD) begin
        if (cam < NUM_CAMERAS) begin
          if (waiting && held > 0) begin
            g = (oldest + held - 1) % GROUP_DEPTH;
            if (slot_filled[g][cam])
              step = {step, make_result(KIND_FREED, cam, handle_store[g][cam])};
          end else begin
            if (held >= GROUP_DEPTH) begin
              // FIFO full: drop the oldest group, freeing whatever it holds
              for (int c = 0; c < NUM_CAMERAS; c++) begin
                if (slot_filled[oldest][c])
                  step = {step, make_result(KIND_FREED, c, handle_store[oldest][c])};
              end
              slot_filled[oldest] = '0;
              oldest = (oldest + 1) % GROUP_DEPTH;
              held--;
            end
            g = (oldest + held) % GROUP_DEPTH;
            slot_filled[g] = '0;
            held++;
          end
          handle_store[g][cam] = it.frame_handle;
          slot_filled[g][cam] = 1'b1;
          waiting = (slot_filled[g] != '1);
        end
        if (step.size() == 0) step = {step, make_result(KIND_ADD_DONE, 0, '0)};
      end else begin
        if (held > 0 && slot_filled[oldest] == '1) begin
          for (int c = 0; c < NUM_CAMERAS; c++)
            step = {step, make_result(KIND_DELIVERED, c, handle_store[oldest][c])};
          slot_filled[oldest] = '0;
          oldest = (oldest + 1) % GROUP_DEPTH;
          held--;
        end else begin
          step = {step, make_result(KIND_NOT_READY, 0, '0)};
        end
      end
      foreach (step[i]) begin
        r = step[i];
        r.groups_held = held[HELD_FIELD_W-1:0];
        r.last = (i == step.size() - 1);
        pending_results = {pending_results, r};
      end
    endfunction

    function void compare_field(string name, int exp_val, int act_val);
      if (exp_val != act_val) begin
        $error("%s mismatch: expected %0d, actual %0d", name, exp_val, act_val);
        error_count++;
      end
    endfunction

    function void check_result(out_item_t act);
      out_item_t exp_r;
      if (pending_results.size() == 0) begin
        $error("unexpected result: kind %0d cam %0d handle %0h",
               act.kind, act.camera_index_res, act.frame_handle_res);
        error_count++;
        return;
      end
      exp_r = pending_results.pop_front();
      compare_field("kind", exp_r.kind, act.kind);
      compare_field("camera_index_res", exp_r.camera_index_res, act.camera_index_res);
      compare_field("frame_handle_res", exp_r.frame_handle_res, act.frame_handle_res);
      compare_field("last", exp_r.last, act.last);
      compare_field("groups_held", exp_r.groups_held, act.groups_held);
    endfunction

    function int pending_count();
      return pending_results.size();
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  in_item = '0;
  logic      out_valid;
  out_item_t out_item;

  frame_group_scoreboard sb = new();
  int unsigned cycle_count = 0;
  bit          gaps_on = 1'b1;

  multi_camera_frame_grouper #(
    .GROUP_DEPTH(GROUP_DEPTH),
    .NUM_CAMERAS(NUM_CAMERAS),
    .HANDLE_WIDTH(HANDLE_WIDTH)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_item(out_item)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n && out_valid) sb.check_result(out_item);
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  // hold start until the transaction is taken
  task send_item(input in_item_t it);
    start <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    sb.note_input(it);
  endtask

  task send_add(input int cam, input logic [HANDLE_FIELD_W-1:0] h);
    in_item_t it;
    it.func = FUNC_ADD;
    it.camera_index = cam[CAM_FIELD_W-1:0];
    it.frame_handle = h;
    send_item(it);
  endtask

  task send_fetch();
    in_item_t it;
    it.func = FUNC_FETCH;
    it.camera_index = CAM_FIELD_W'($urandom_range(7));
    it.frame_handle = HANDLE_FIELD_W'($urandom_range(16'hffff));
    send_item(it);
  endtask

  // mostly short gaps, occasionally long ones
  task sender_gap();
    int pick;
    int n;
    pick = $urandom_range(99);
    if (!gaps_on || pick < 55) n = 0;
    else if (pick < 90) n = $urandom_range(3, 1);
    else n = $urandom_range(30, 5);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task drain();
    start <= 1'b0;
    do @(posedge clk); while (sb.pending_count() != 0);
  endtask

  task random_phase(input int n_items, input int fetch_pct);
    in_item_t it;
    for (int i = 0; i < n_items; i++) begin
      it.func = ($urandom_range(99) < fetch_pct) ? FUNC_FETCH : FUNC_ADD;
      // a few adds aimed at cameras that do not exist
      if ($urandom_range(99) < 8)
        it.camera_index = CAM_FIELD_W'($urandom_range(7, NUM_CAMERAS));
      else
        it.camera_index = CAM_FIELD_W'($urandom_range(NUM_CAMERAS - 1));
      it.frame_handle = HANDLE_FIELD_W'($urandom_range(16'hffff));
      send_item(it);
      sender_gap();
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    send_fetch();                 // empty FIFO
    send_add(7, 16'hffff);        // camera out of range
    send_add(0, 16'h0000);
    send_add(0, 16'hffff);        // replaces and frees the first handle
    send_fetch();                 // oldest not complete yet
    send_add(1, 16'h1234);
    send_fetch();                 // delivers both
    for (int g = 0; g < GROUP_DEPTH; g++) begin
      send_add(1, HANDLE_FIELD_W'(32'ha000 + g));
      send_add(0, HANDLE_FIELD_W'(32'h5000 + g));
      sender_gap();
    end
    send_add(0, 16'h8001);        // FIFO full: oldest group dropped
    send_fetch();
    drain();

    for (int p = 0; p < 6; p++) begin
      gaps_on = (p != 2);
      random_phase(50, (p % 2 == 0) ? 15 : 55);
      if (p == 3) drain();
    end
    start <= 1'b0;

    while (sb.pending_count() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (sb.error_count == 0 && sb.pending_count() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
